### rtl/lml_pkg.sv
// Shared types and constants of the manifest lexer.
package lml_pkg;

  localparam int MAX_LEVEL_DEF   = 8;
  localparam int LINE_BITS_DEF   = 24;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int Q_DEPTH         = 4;

  localparam logic [3:0] KIND_NAME   = 4'd0;
  localparam logic [3:0] KIND_STRING = 4'd1;
  localparam logic [3:0] KIND_NUMBER = 4'd2;
  localparam logic [3:0] KIND_LBRACE = 4'd3;
  localparam logic [3:0] KIND_RBRACE = 4'd4;
  localparam logic [3:0] KIND_LPAREN = 4'd5;
  localparam logic [3:0] KIND_RPAREN = 4'd6;
  localparam logic [3:0] KIND_COMMA  = 4'd7;
  localparam logic [3:0] KIND_SEMI   = 4'd8;
  localparam logic [3:0] KIND_EQUALS = 4'd9;
  localparam logic [3:0] KIND_OTHER  = 4'd10;
  localparam logic [3:0] KIND_EOF    = 4'd11;
  localparam logic [3:0] KIND_ERROR  = 4'd12;

  localparam logic [3:0] ERR_OPEN_COMMENT = 4'd0;
  localparam logic [3:0] ERR_OPEN_STRING  = 4'd1;
  localparam logic [3:0] ERR_OPEN_ESCAPE  = 4'd2;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
  localparam logic [3:0] ERR_NO_BRACE     = 4'd4;
  localparam logic [3:0] ERR_BAD_UNICODE  = 4'd5;
  localparam logic [3:0] ERR_DEC_RANGE    = 4'd6;
  localparam logic [3:0] ERR_UNKNOWN_ESC  = 4'd7;
  localparam logic [3:0] ERR_OPEN_LONG    = 4'd8;
  localparam logic [3:0] ERR_LEVEL_DEEP   = 4'd9;

  // Fixed-width part of one result word.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] text;
    logic       has;
    logic [3:0] err;
    logic       tend;
    logic       rend;
  } lml_res_t;

endpackage

### rtl/lml_front.sv
// Front end of the manifest lexer: byte intake, lexer sequencer and result staging.
module lml_front import lml_pkg::*; #(
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [7:0]             in_source_byte,
  input  logic                   q_full,
  output logic                   q_push,
  output lml_res_t               q_res,
  output logic [LINE_BITS-1:0]   q_line,
  output logic [COLUMN_BITS-1:0] q_col
);

  localparam int LVL_W = $clog2(MAX_LEVEL + 1);
  localparam int SUB_W = (LVL_W > 2) ? LVL_W : 2;

  typedef enum logic [4:0] {
    PH_BOM, PH_TRIVIA, PH_DASH, PH_DASH2, PH_LINECMT,
    PH_CMT_EQ, PH_CMT_CR, PH_CMT_LF, PH_CMT_BODY, PH_CMT_CLOSE,
    PH_STR_EQ, PH_STR_CR, PH_STR_LF, PH_STR_BODY, PH_STR_CLOSE,
    PH_NAME, PH_NUMBER, PH_DOT, PH_EQUAL, PH_QUOTE, PH_ESC,
    PH_HEX1, PH_HEX2, PH_ZSKIP, PH_UBRACE, PH_UDIGITS, PH_DEC, PH_DEAD
  } phase_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_name_start(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction
  function automatic logic is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    else v = c - "A" + 8'd10;
    return v[3:0];
  endfunction
  function automatic logic [7:0] bom_byte(logic [1:0] i);
    case (i)
      2'd0:    return 8'hEF;
      2'd1:    return 8'hBB;
      default: return 8'hBF;
    endcase
  endfunction

  phase_t                 phase_r, phase_nxt;
  logic [LINE_BITS-1:0]   cl_r, cl_nxt, sl_r, sl_nxt, el_r, el_nxt;
  logic [COLUMN_BITS-1:0] cc_r, cc_nxt, sc_r, sc_nxt, ec_r, ec_nxt;
  logic [LVL_W-1:0]       lvl_r, lvl_nxt, clo_r, clo_nxt;
  logic [SUB_W-1:0]       sub_r, sub_nxt;
  logic                   dq_r, dq_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [1:0]             dcnt_r, dcnt_nxt, bom_r, bom_nxt;
  logic [8:0]             held_r, held_nxt;
  logic                   hv_r, hmode_r;
  logic [7:0]             hbyte_r;
  logic                   pend_v_r, pend_closed_r;
  lml_res_t               pend_res_r;
  logic [LINE_BITS-1:0]   pend_line_r;
  logic [COLUMN_BITS-1:0] pend_col_r;

  logic                   eos, go, done, emit, do_adv, rst_all, nl;
  logic [7:0]             b;
  lml_res_t               e_res;
  logic [LINE_BITS-1:0]   e_line, a_line;
  logic [COLUMN_BITS-1:0] e_col, a_col, col_off;
  logic                   t_req, f_req, fl_req;
  logic [3:0]             t_kind, f_kind, fl_code;
  logic [7:0]             t_byte;
  logic [LINE_BITS-1:0]   fl_line;
  logic [COLUMN_BITS-1:0] fl_col;
  logic [SUB_W-1:0]       k;
  logic [SUB_W-1:0]       lvl_ext;
  logic [COLUMN_BITS:0]   col_sum;
  logic [31:0]            dec_acc;
  logic [1:0]             u_last, u_dist;
  logic [7:0]             u_byte, num_prev;

  assign eos     = hmode_r;
  assign b       = hbyte_r;
  assign go      = hv_r && !(pend_v_r && q_full);
  assign in_ready = !hv_r || (go && done);
  assign nl      = !eos && b == 8'h0A;
  assign a_line  = (nl && cl_r != '1) ? cl_r + 1'b1 : cl_r;
  assign a_col   = nl ? COLUMN_BITS'(1) : ((cc_r != '1) ? cc_r + 1'b1 : cc_r);
  assign lvl_ext = SUB_W'(lvl_r);
  assign k       = sub_r - 1'b1;
  assign col_sum = {1'b0, sc_r} + (COLUMN_BITS + 1)'({k[SUB_W-1:1], 1'b0})
                   + (COLUMN_BITS + 1)'(1);
  assign col_off = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
  assign dec_acc = (acc_r << 3) + (acc_r << 1) + 32'(b - "0");
  assign num_prev = held_r[8] ? held_r[7:0] : 8'd0;

  always_comb begin
    if (acc_r < 32'h80) u_last = 2'd0;
    else if (acc_r < 32'h800) u_last = 2'd1;
    else if (acc_r < 32'h10000) u_last = 2'd2;
    else u_last = 2'd3;
    u_dist = u_last - sub_r[1:0];
    if (sub_r[1:0] == 2'd0) begin
      case (u_last)
        2'd0:    u_byte = acc_r[7:0];
        2'd1:    u_byte = 8'hC0 | {3'b0, acc_r[10:6]};
        2'd2:    u_byte = 8'hE0 | {4'b0, acc_r[15:12]};
        default: u_byte = 8'hF0 | acc_r[25:18];
      endcase
    end else begin
      case (u_dist)
        2'd0:    u_byte = 8'h80 | {2'b0, acc_r[5:0]};
        2'd1:    u_byte = 8'h80 | {2'b0, acc_r[11:6]};
        default: u_byte = 8'h80 | {2'b0, acc_r[17:12]};
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cl_nxt = cl_r; cc_nxt = cc_r; sl_nxt = sl_r; sc_nxt = sc_r;
    el_nxt = el_r; ec_nxt = ec_r;
    lvl_nxt = lvl_r; clo_nxt = clo_r; sub_nxt = sub_r; dq_nxt = dq_r;
    acc_nxt = acc_r; dcnt_nxt = dcnt_r; bom_nxt = bom_r; held_nxt = held_r;
    emit = 1'b0; done = 1'b0; do_adv = 1'b0; rst_all = 1'b0;
    e_res = '0; e_line = sl_r; e_col = sc_r;
    t_req = 1'b0; t_kind = KIND_STRING; t_byte = b;
    f_req = 1'b0; f_kind = KIND_STRING;
    fl_req = 1'b0; fl_code = ERR_OPEN_COMMENT; fl_line = sl_r; fl_col = sc_r;

    case (phase_r)
      PH_BOM: begin
        if (!eos && sub_r == '0 && b == bom_byte(bom_r)) begin
          done = 1'b1;
          if (bom_r == 2'd2) begin
            bom_nxt = 2'd0;
            phase_nxt = PH_TRIVIA;
          end else begin
            bom_nxt = bom_r + 1'b1;
          end
        end else if (bom_r == 2'd0) begin
          phase_nxt = PH_TRIVIA;
        end else begin
          // Replay the partial mark as ordinary bytes, one per cycle unless the queue is full.
          emit = 1'b1;
          e_res.kind = KIND_OTHER; e_res.text = bom_byte(sub_r[1:0]);
          e_res.has = 1'b1; e_res.tend = 1'b1;
          e_line = cl_r; e_col = cc_r;
          sl_nxt = cl_r; sc_nxt = cc_r;
          cc_nxt = (cc_r != '1) ? cc_r + 1'b1 : cc_r;
          if (sub_r[1:0] + 2'd1 == bom_r) begin
            sub_nxt = '0; bom_nxt = 2'd0; phase_nxt = PH_TRIVIA;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end
      end
      PH_TRIVIA: begin
        done = 1'b1;
        if (eos) begin
          emit = 1'b1;
          e_res.kind = KIND_EOF; e_res.tend = 1'b1;
          e_line = cl_r; e_col = cc_r;
          rst_all = 1'b1;
        end else if (is_space(b)) begin
          do_adv = 1'b1;
        end else begin
          sl_nxt = cl_r; sc_nxt = cc_r; do_adv = 1'b1; held_nxt = '0;
          e_line = cl_r; e_col = cc_r;
          e_res.text = b; e_res.has = 1'b1; e_res.tend = 1'b1;
          if (b == "-") phase_nxt = PH_DASH;
          else if (b == "'" || b == "\"") begin
            dq_nxt = (b == "\""); phase_nxt = PH_QUOTE;
          end else if (b == "[") begin
            lvl_nxt = '0; phase_nxt = PH_STR_EQ;
          end else if (is_name_start(b)) begin
            held_nxt = {1'b1, b}; phase_nxt = PH_NAME;
          end else if (is_digit(b)) begin
            held_nxt = {1'b1, b}; phase_nxt = PH_NUMBER;
          end else if (b == ".") phase_nxt = PH_DOT;
          else if (b == "=") phase_nxt = PH_EQUAL;
          else begin
            emit = 1'b1;
            case (b)
              "{":     e_res.kind = KIND_LBRACE;
              "}":     e_res.kind = KIND_RBRACE;
              "(":     e_res.kind = KIND_LPAREN;
              ")":     e_res.kind = KIND_RPAREN;
              ",":     e_res.kind = KIND_COMMA;
              ";":     e_res.kind = KIND_SEMI;
              default: e_res.kind = KIND_OTHER;
            endcase
          end
        end
      end
      PH_DASH: begin
        if (!eos && b == "-") begin
          do_adv = 1'b1; phase_nxt = PH_DASH2; done = 1'b1;
        end else begin
          emit = 1'b1;
          e_res.kind = KIND_OTHER; e_res.text = "-"; e_res.has = 1'b1; e_res.tend = 1'b1;
          phase_nxt = PH_TRIVIA;
        end
      end
      PH_DASH2: begin
        if (!eos && b == "[") begin
          do_adv = 1'b1; lvl_nxt = '0; phase_nxt = PH_CMT_EQ; done = 1'b1;
        end else begin
          phase_nxt = PH_LINECMT;
        end
      end
      PH_LINECMT: begin
        if (eos || b == 8'h0A) phase_nxt = PH_TRIVIA;
        else begin
          do_adv = 1'b1; done = 1'b1;
        end
      end
      PH_STR_EQ, PH_CMT_EQ: begin
        if (sub_r == '0 && !eos && b == "=") begin
          done = 1'b1;
          if (lvl_r >= LVL_W'(MAX_LEVEL)) begin
            fl_req = 1'b1; fl_code = ERR_LEVEL_DEEP;
          end else begin
            do_adv = 1'b1; lvl_nxt = lvl_r + 1'b1;
          end
        end else if (sub_r == '0 && !eos && b == "[") begin
          do_adv = 1'b1; held_nxt = '0; done = 1'b1;
          phase_nxt = (phase_r == PH_STR_EQ) ? PH_STR_CR : PH_CMT_CR;
        end else if (phase_r == PH_CMT_EQ) begin
          phase_nxt = PH_LINECMT;
        end else begin
          // Unfold "[" and the "=" run into separate tokens, one per cycle unless the queue is full.
          emit = 1'b1; e_res.has = 1'b1;
          if (sub_r == '0) begin
            e_res.kind = KIND_OTHER; e_res.text = "["; e_res.tend = 1'b1;
          end else begin
            e_res.text = "="; e_col = col_off;
            e_res.kind = (!k[0] && sub_r == lvl_ext) ? KIND_EQUALS : KIND_OTHER;
            e_res.tend = k[0] || (sub_r == lvl_ext);
          end
          if (sub_r == lvl_ext) begin
            sub_nxt = '0; lvl_nxt = '0; phase_nxt = PH_TRIVIA;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end
      end
      PH_STR_CR, PH_CMT_CR: begin
        phase_nxt = (phase_r == PH_STR_CR) ? PH_STR_LF : PH_CMT_LF;
        if (!eos && b == 8'h0D) begin
          do_adv = 1'b1; done = 1'b1;
        end
      end
      PH_STR_LF, PH_CMT_LF: begin
        phase_nxt = (phase_r == PH_STR_LF) ? PH_STR_BODY : PH_CMT_BODY;
        if (nl) begin
          do_adv = 1'b1; done = 1'b1;
        end
      end
      PH_STR_BODY, PH_CMT_BODY: begin
        done = 1'b1;
        if (eos) begin
          fl_req = 1'b1;
          fl_code = (phase_r == PH_STR_BODY) ? ERR_OPEN_LONG : ERR_OPEN_COMMENT;
        end else begin
          do_adv = 1'b1;
          if (b == "]") begin
            clo_nxt = '0;
            phase_nxt = (phase_r == PH_STR_BODY) ? PH_STR_CLOSE : PH_CMT_CLOSE;
          end else if (phase_r == PH_STR_BODY) begin
            t_req = 1'b1;
          end
        end
      end
      PH_STR_CLOSE, PH_CMT_CLOSE: begin
        if (sub_r != '0) begin
          // Draining the "=" bytes of a close that did not match.
          t_req = 1'b1; t_byte = "=";
          clo_nxt = clo_r - 1'b1;
          if (clo_r == LVL_W'(1)) begin
            sub_nxt = '0; clo_nxt = '0;
            if (!eos && b == "]") begin
              do_adv = 1'b1; done = 1'b1;
            end else begin
              phase_nxt = PH_STR_BODY;
            end
          end
        end else if (eos) begin
          done = 1'b1; fl_req = 1'b1;
          fl_code = (phase_r == PH_STR_CLOSE) ? ERR_OPEN_LONG : ERR_OPEN_COMMENT;
        end else if (b == "=" && clo_r < lvl_r) begin
          do_adv = 1'b1; clo_nxt = clo_r + 1'b1; done = 1'b1;
        end else if (b == "]" && clo_r == lvl_r) begin
          do_adv = 1'b1; done = 1'b1;
          f_req = (phase_r == PH_STR_CLOSE);
          clo_nxt = '0; lvl_nxt = '0; phase_nxt = PH_TRIVIA;
        end else begin
          if (phase_r == PH_STR_CLOSE) begin
            t_req = 1'b1; t_byte = "]";
          end
          if (phase_r == PH_STR_CLOSE && clo_r != '0) begin
            sub_nxt = SUB_W'(1);
          end else begin
            clo_nxt = '0;
            if (b == "]") begin
              do_adv = 1'b1; done = 1'b1;
            end else begin
              phase_nxt = (phase_r == PH_STR_CLOSE) ? PH_STR_BODY : PH_CMT_BODY;
            end
          end
        end
      end
      PH_NAME: begin
        if (!eos && (is_name_start(b) || is_digit(b))) begin
          do_adv = 1'b1; t_req = 1'b1; t_kind = KIND_NAME; done = 1'b1;
        end else begin
          f_req = 1'b1; f_kind = KIND_NAME; phase_nxt = PH_TRIVIA;
        end
      end
      PH_NUMBER: begin
        if (!eos && (is_name_start(b) || is_digit(b) || b == "." ||
            ((b == "-" || b == "+") && (num_prev == "e" || num_prev == "E")))) begin
          do_adv = 1'b1; t_req = 1'b1; t_kind = KIND_NUMBER; done = 1'b1;
        end else begin
          f_req = 1'b1; f_kind = KIND_NUMBER; phase_nxt = PH_TRIVIA;
        end
      end
      PH_DOT: begin
        if (!eos && is_digit(b)) begin
          held_nxt = {1'b1, 8'(".")}; phase_nxt = PH_NUMBER;
        end else begin
          emit = 1'b1;
          e_res.kind = KIND_OTHER; e_res.text = "."; e_res.has = 1'b1; e_res.tend = 1'b1;
          phase_nxt = PH_TRIVIA;
        end
      end
      PH_EQUAL: begin
        emit = 1'b1; e_res.text = "="; e_res.has = 1'b1;
        if (sub_r != '0) begin
          e_res.kind = KIND_OTHER; e_res.tend = 1'b1;
          sub_nxt = '0; phase_nxt = PH_TRIVIA; done = 1'b1;
        end else if (!eos && b == "=") begin
          e_res.kind = KIND_OTHER; do_adv = 1'b1; sub_nxt = SUB_W'(1);
        end else begin
          e_res.kind = KIND_EQUALS; e_res.tend = 1'b1; phase_nxt = PH_TRIVIA;
        end
      end
      PH_QUOTE: begin
        done = 1'b1;
        if (eos || b == 8'h0A) begin
          fl_req = 1'b1; fl_code = ERR_OPEN_STRING;
        end else begin
          do_adv = 1'b1;
          if (b == (dq_r ? 8'h22 : 8'h27)) begin
            f_req = 1'b1; phase_nxt = PH_TRIVIA;
          end else if (b == "\\") phase_nxt = PH_ESC;
          else t_req = 1'b1;
        end
      end
      PH_ESC: begin
        done = 1'b1;
        if (eos) begin
          fl_req = 1'b1; fl_code = ERR_OPEN_ESCAPE;
        end else begin
          do_adv = 1'b1; phase_nxt = PH_QUOTE;
          case (b)
            "n": begin t_req = 1'b1; t_byte = 8'd10; end
            "t": begin t_req = 1'b1; t_byte = 8'd9;  end
            "r": begin t_req = 1'b1; t_byte = 8'd13; end
            "a": begin t_req = 1'b1; t_byte = 8'd7;  end
            "b": begin t_req = 1'b1; t_byte = 8'd8;  end
            "f": begin t_req = 1'b1; t_byte = 8'd12; end
            "v": begin t_req = 1'b1; t_byte = 8'd11; end
            "\\", "'", "\"", 8'h0A: t_req = 1'b1;
            "x": begin
              el_nxt = a_line; ec_nxt = a_col; phase_nxt = PH_HEX1;
            end
            "z": phase_nxt = PH_ZSKIP;
            "u": phase_nxt = PH_UBRACE;
            default: begin
              if (is_digit(b)) begin
                acc_nxt = 32'(b - "0"); dcnt_nxt = 2'd1; phase_nxt = PH_DEC;
              end else begin
                fl_req = 1'b1; fl_code = ERR_UNKNOWN_ESC; fl_line = a_line; fl_col = a_col;
              end
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        done = 1'b1;
        if (eos || !is_hex(b)) begin
          fl_req = 1'b1; fl_code = ERR_BAD_HEX; fl_line = el_r; fl_col = ec_r;
        end else begin
          do_adv = 1'b1;
          if (phase_r == PH_HEX1) begin
            acc_nxt = 32'(hex_val(b)); phase_nxt = PH_HEX2;
          end else begin
            t_req = 1'b1; t_byte = {acc_r[3:0], hex_val(b)}; phase_nxt = PH_QUOTE;
          end
        end
      end
      PH_ZSKIP: begin
        if (!eos && is_space(b)) begin
          do_adv = 1'b1; done = 1'b1;
        end else begin
          phase_nxt = PH_QUOTE;
        end
      end
      PH_UBRACE: begin
        done = 1'b1;
        if (eos || b != "{") begin
          fl_req = 1'b1; fl_code = ERR_NO_BRACE; fl_line = cl_r; fl_col = cc_r;
        end else begin
          do_adv = 1'b1; acc_nxt = '0; dcnt_nxt = 2'd0; phase_nxt = PH_UDIGITS;
        end
      end
      PH_UDIGITS: begin
        if (sub_r != '0 || (!eos && b == "}" && dcnt_r != 2'd0)) begin
          // One UTF-8 byte per cycle unless the queue is full.
          do_adv = (sub_r == '0);
          t_req = 1'b1; t_byte = u_byte;
          if (sub_r[1:0] == u_last) begin
            sub_nxt = '0; phase_nxt = PH_QUOTE; done = 1'b1;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end else if (!eos && is_hex(b)) begin
          do_adv = 1'b1; acc_nxt = {acc_r[27:0], hex_val(b)}; dcnt_nxt = 2'd1; done = 1'b1;
        end else begin
          fl_req = 1'b1; fl_code = ERR_BAD_UNICODE; fl_line = cl_r; fl_col = cc_r;
          done = 1'b1;
        end
      end
      PH_DEC: begin
        if (!eos && is_digit(b)) begin
          done = 1'b1; do_adv = 1'b1; acc_nxt = dec_acc; dcnt_nxt = dcnt_r + 1'b1;
          if (dcnt_r == 2'd2) begin
            if (dec_acc[31:8] != '0) begin
              fl_req = 1'b1; fl_code = ERR_DEC_RANGE; fl_line = a_line; fl_col = a_col;
            end else begin
              t_req = 1'b1; t_byte = dec_acc[7:0]; phase_nxt = PH_QUOTE;
            end
          end
        end else begin
          t_req = 1'b1; t_byte = acc_r[7:0]; phase_nxt = PH_QUOTE;
        end
      end
      default: begin
        done = 1'b1;
        if (eos) rst_all = 1'b1;
      end
    endcase

    if (do_adv) begin
      cl_nxt = a_line; cc_nxt = a_col;
    end
    if (t_req) begin
      emit = held_r[8];
      e_res = '0; e_res.kind = t_kind; e_res.text = held_r[7:0]; e_res.has = 1'b1;
      e_line = sl_r; e_col = sc_r;
      held_nxt = {1'b1, t_byte};
    end
    if (f_req) begin
      emit = 1'b1;
      e_res = '0; e_res.kind = f_kind; e_res.text = held_r[8] ? held_r[7:0] : 8'd0;
      e_res.has = held_r[8]; e_res.tend = 1'b1;
      e_line = sl_r; e_col = sc_r;
      held_nxt = '0;
    end
    if (fl_req) begin
      emit = 1'b1;
      e_res = '0; e_res.kind = KIND_ERROR; e_res.err = fl_code; e_res.tend = 1'b1;
      e_line = fl_line; e_col = fl_col;
      held_nxt = '0; phase_nxt = PH_DEAD; sub_nxt = '0;
    end
    if (rst_all) begin
      phase_nxt = PH_BOM;
      cl_nxt = LINE_BITS'(1); sl_nxt = LINE_BITS'(1); el_nxt = LINE_BITS'(1);
      cc_nxt = COLUMN_BITS'(1); sc_nxt = COLUMN_BITS'(1); ec_nxt = COLUMN_BITS'(1);
      lvl_nxt = '0; clo_nxt = '0; sub_nxt = '0; dq_nxt = 1'b0;
      acc_nxt = '0; dcnt_nxt = '0; bom_nxt = '0; held_nxt = '0;
    end
  end

  assign q_push = pend_v_r && !q_full && (pend_closed_r || (go && emit));
  always_comb begin
    q_res      = pend_res_r;
    q_res.rend = pend_closed_r;
  end
  assign q_line = pend_line_r;
  assign q_col  = pend_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BOM;
      cl_r <= LINE_BITS'(1); sl_r <= LINE_BITS'(1); el_r <= LINE_BITS'(1);
      cc_r <= COLUMN_BITS'(1); sc_r <= COLUMN_BITS'(1); ec_r <= COLUMN_BITS'(1);
      lvl_r <= '0; clo_r <= '0; sub_r <= '0; dq_r <= 1'b0;
      acc_r <= '0; dcnt_r <= '0; bom_r <= '0; held_r <= '0;
      hv_r <= 1'b0; pend_v_r <= 1'b0; pend_closed_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hv_r <= 1'b1; hmode_r <= in_mode; hbyte_r <= in_source_byte;
      end else if (go && done) begin
        hv_r <= 1'b0;
      end
      if (go) begin
        phase_r <= phase_nxt;
        cl_r <= cl_nxt; cc_r <= cc_nxt; sl_r <= sl_nxt; sc_r <= sc_nxt;
        el_r <= el_nxt; ec_r <= ec_nxt;
        lvl_r <= lvl_nxt; clo_r <= clo_nxt; sub_r <= sub_nxt; dq_r <= dq_nxt;
        acc_r <= acc_nxt; dcnt_r <= dcnt_nxt; bom_r <= bom_nxt; held_r <= held_nxt;
      end
      if (go && emit) begin
        pend_v_r <= 1'b1; pend_closed_r <= done;
        pend_res_r <= e_res; pend_line_r <= e_line; pend_col_r <= e_col;
      end else if (q_push) begin
        pend_v_r <= 1'b0; pend_closed_r <= 1'b0;
      end else if (go && done && pend_v_r) begin
        pend_closed_r <= 1'b1;
      end
    end
  end

endmodule

### rtl/lml_queue.sv
// Result queue and output stage of the manifest lexer.
module lml_queue import lml_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] rdata
);

  localparam int PW = $clog2(Q_DEPTH);

  logic [W-1:0]  mem_r [Q_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          pop;

  assign full      = cnt_r == (PW + 1)'(Q_DEPTH);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign rdata     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

endmodule

### rtl/lua_style_manifest_lexer.sv
// Top level of the streaming manifest lexer.
// Usage: source bytes enter on the in_ channel, one word per byte, with
// in_mode high for the end-of-source word. Token results leave on the out_
// channel, one word per text byte, with line and column of the token start.
// The front sequencer takes a byte through its phases and issues its results
// one after another; back-to-back words are taken at full rate while the queue
// has room and each byte needs a single phase. A byte that ends a name or a
// number, follows a lone "-" or ".", or starts a source without a byte order
// mark passes through one more phase; the second "=" of "==" gives two results,
// and a bracket with n "=" that opens nothing gives n + 1 results on the byte after it.
// A result can be taken at the earliest after its byte has passed the intake
// register, the staging register that marks the last result of a byte, and
// the four-entry result queue. It comes later when its byte needs more phases
// or it waits behind earlier results.
// Text bytes lag by one source byte so the last byte can carry token_end.
// When the receiver stalls, the queue fills and then the front stops and
// drops in_ready; nothing is lost. After reset the lexer sits at start of
// source with line and column one; an end-of-source word resets it again.
module lua_style_manifest_lexer import lml_pkg::*; #(
  parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [7:0]             in_source_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_token_kind,
  output logic [7:0]             out_text_byte,
  output logic                   out_has_byte,
  output logic [3:0]             out_error_code,
  output logic [LINE_BITS-1:0]   out_token_line,
  output logic [COLUMN_BITS-1:0] out_token_column,
  output logic                   out_token_end,
  output logic                   out_run_end
);

  localparam int RW = $bits(lml_res_t);
  localparam int QW = LINE_BITS + COLUMN_BITS + RW;

  logic                   q_full, q_push;
  lml_res_t               q_res, o_res;
  logic [LINE_BITS-1:0]   q_line;
  logic [COLUMN_BITS-1:0] q_col;
  logic [QW-1:0]          q_rdata;

  // The front classifies bytes and runs the lexer; it may stall on its own.
  lml_front #(
    .MAX_LEVEL(MAX_LEVEL), .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_source_byte(in_source_byte),
    .q_full(q_full), .q_push(q_push),
    .q_res(q_res), .q_line(q_line), .q_col(q_col)
  );

  // The queue decouples the lexer from the receiver.
  lml_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata({q_line, q_col, q_res}), .full(q_full),
    .out_valid(out_valid), .out_ready(out_ready), .rdata(q_rdata)
  );

  assign o_res            = q_rdata[RW-1:0];
  assign out_token_column = q_rdata[RW +: COLUMN_BITS];
  assign out_token_line   = q_rdata[RW + COLUMN_BITS +: LINE_BITS];
  assign out_token_kind   = o_res.kind;
  assign out_text_byte    = o_res.text;
  assign out_has_byte     = o_res.has;
  assign out_error_code   = o_res.err;
  assign out_token_end    = o_res.tend;
  assign out_run_end      = o_res.rend;

endmodule
